[sv/motor_speed_pid_step_unit_macros.svh]
// Assertion macros shared by the verification side of the PID speed step unit.
// No dependencies; included by the checker file.
`ifndef MOTOR_SPEED_PID_STEP_UNIT_MACROS_SVH
`define MOTOR_SPEED_PID_STEP_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MSPID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define MSPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks across reset.
`define MSPID_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mspid_pkg.sv]
// Shared widths, codes, constants and types of the PID speed step unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mspid_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int GAIN_WIDTH      = 8;
   localparam int RAW_WIDTH       = 10;
   localparam int SPEED_WIDTH     = 8;
   localparam int ERR_WIDTH       = 10;
   localparam int DIFF_WIDTH      = 11;
   localparam int P_WIDTH         = 19;
   localparam int KI_ERR_WIDTH    = 19;
   localparam int KD_DIFF_WIDTH   = 20;
   localparam int D_WIDTH         = 26;
   localparam int INTEGRAL_WIDTH  = 24;
   localparam int DUTY_WIDTH      = 10;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int DUTY_MAX_DEFAULT = 1023;
   localparam int PWM_CAP          = 1023;

   localparam logic CMD_PULSE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KP = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KI = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KD = 2'd2;

   localparam logic [GAIN_WIDTH-1:0] KP_RESET = 8'd3;
   localparam logic [GAIN_WIDTH-1:0] KI_RESET = 8'd1;
   localparam logic [GAIN_WIDTH-1:0] KD_RESET = 8'd1;

   // count*2400/360 = count*20/3 passes 255 from this count on
   localparam logic [COUNT_WIDTH-1:0] SPEED_SAT_COUNT = 16'd39;
   localparam logic [SPEED_WIDTH-1:0] SPEED_MAX       = 8'd255;

   localparam int SETPOINT_SCALE = 360;
   localparam int SETPOINT_SHIFT = 10;

   // floor(x/3) = (x*683) >> 11 for x below 1024
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   // floor(x/5) = (x*13108) >> 16 for x below 16384
   localparam int RECIP5       = 13108;
   localparam int RECIP5_SHIFT = 16;

   typedef struct packed {
      logic                             load_tick;
      logic                             load_pulse;
      logic                             move;
   } pipe_ctl_type;

   typedef struct packed {
      logic [SPEED_WIDTH-1:0]           speed;
      logic signed [ERR_WIDTH-1:0]      err;
      logic signed [P_WIDTH-1:0]        p;
      logic signed [KI_ERR_WIDTH-1:0]   ki_err;
      logic signed [KD_DIFF_WIDTH-1:0]  kd_diff;
   } err_word_type;

   // Speed for a count below SPEED_SAT_COUNT: floor(cnt*20/3)
   function automatic logic [SPEED_WIDTH-1:0] speed_of_count(input logic [5:0] cnt);
      logic [9:0]  scaled;
      logic [19:0] prod;
      scaled = {cnt, 4'b0000} + {2'b00, cnt, 2'b00};
      prod   = {10'd0, scaled} * 20'(RECIP3);
      return prod[RECIP3_SHIFT +: SPEED_WIDTH];
   endfunction

endpackage

[sv/mspid_err_stage.sv]
// First stage: pulse counter, speed and error forming, gain products.
// Depends on mspid_pkg.
`timescale 1ns / 1ps

module mspid_err_stage (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mspid_pkg::pipe_ctl_type                ctl,
   input  logic [mspid_pkg::RAW_WIDTH-1:0]        setpoint_raw,
   input  logic [mspid_pkg::GAIN_WIDTH-1:0]       kp,
   input  logic [mspid_pkg::GAIN_WIDTH-1:0]       ki,
   input  logic [mspid_pkg::GAIN_WIDTH-1:0]       kd,
   output logic                                   word_valid,
   output mspid_pkg::err_word_type                word
);
   import mspid_pkg::*;

   logic [COUNT_WIDTH-1:0]               pulse_count_ff, pulse_count_in;
   logic signed [ERR_WIDTH-1:0]          prev_err_ff, prev_err_in;
   logic                                 word_valid_ff, word_valid_in;
   err_word_type                         word_ff, word_in;

   logic [SPEED_WIDTH-1:0]               speed;
   logic [RAW_WIDTH+8:0]                 target_prod;
   logic [SPEED_WIDTH:0]                 target;
   logic signed [ERR_WIDTH-1:0]          err;
   logic signed [DIFF_WIDTH-1:0]         diff;

   always_comb begin
      if (pulse_count_ff >= SPEED_SAT_COUNT) begin
         speed = SPEED_MAX;
      end else begin
         speed = speed_of_count(pulse_count_ff[5:0]);
      end
      target_prod = {9'd0, setpoint_raw} * 19'(SETPOINT_SCALE);
      target      = target_prod[SETPOINT_SHIFT +: SPEED_WIDTH+1];
      err  = $signed({1'b0, target}) - $signed({2'b00, speed});
      diff = $signed({err[ERR_WIDTH-1], err})
           - $signed({prev_err_ff[ERR_WIDTH-1], prev_err_ff});

      word_in.speed   = speed;
      word_in.err     = err;
      word_in.p       = P_WIDTH'($signed({1'b0, kp})) * P_WIDTH'(err);
      word_in.ki_err  = KI_ERR_WIDTH'($signed({1'b0, ki})) * KI_ERR_WIDTH'(err);
      word_in.kd_diff = KD_DIFF_WIDTH'($signed({1'b0, kd})) * KD_DIFF_WIDTH'(diff);
   end

   always_comb begin
      pulse_count_in = pulse_count_ff;
      prev_err_in    = prev_err_ff;
      priority if (ctl.load_tick) begin
         pulse_count_in = '0;
         prev_err_in    = err;
      end else if (ctl.load_pulse && (pulse_count_ff != '1)) begin
         pulse_count_in = pulse_count_ff + 1'b1;
      end
   end

   always_comb begin
      priority if (ctl.load_tick) begin
         word_valid_in = 1'b1;
      end else if (ctl.move) begin
         word_valid_in = 1'b0;
      end else begin
         word_valid_in = word_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff <= '0;
         prev_err_ff    <= '0;
         word_valid_ff  <= 1'b0;
      end else begin
         pulse_count_ff <= pulse_count_in;
         prev_err_ff    <= prev_err_in;
         word_valid_ff  <= word_valid_in;
      end
   end

   // hold the word until the next stage takes it
   always_ff @(posedge clock) begin
      if (ctl.load_tick) begin
         word_ff <= word_in;
      end
   end

   assign word_valid = word_valid_ff;
   assign word       = word_ff;

endmodule

[sv/mspid_acc_stage.sv]
// Second stage: integral and drive accumulation, clamping, result register.
// Depends on mspid_pkg.
`timescale 1ns / 1ps

module mspid_acc_stage #(
   parameter int DUTY_MAX = mspid_pkg::DUTY_MAX_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mspid_pkg::pipe_ctl_type                ctl,
   input  mspid_pkg::err_word_type                word,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic [mspid_pkg::DUTY_WIDTH-1:0]       rsp_duty_cycle,
   output logic [mspid_pkg::SPEED_WIDTH-1:0]      rsp_speed_rpm,
   output logic signed [mspid_pkg::ERR_WIDTH-1:0] rsp_speed_error
);
   import mspid_pkg::*;

   localparam int DRIVE_WIDTH = $clog2(DUTY_MAX + 1);
   localparam int SUM_WIDTH   =
      ((DRIVE_WIDTH > INTEGRAL_WIDTH) ? DRIVE_WIDTH : INTEGRAL_WIDTH) + 3;
   localparam logic signed [INTEGRAL_WIDTH-1:0] INTEGRAL_MAX =
      {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
   localparam logic signed [INTEGRAL_WIDTH-1:0] INTEGRAL_MIN =
      {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

   logic signed [INTEGRAL_WIDTH-1:0]     integral_ff, integral_in;
   logic [DRIVE_WIDTH-1:0]               drive_ff, drive_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_WIDTH-1:0]                duty_ff, duty_in;
   logic [SPEED_WIDTH-1:0]               speed_ff;
   logic signed [ERR_WIDTH-1:0]          error_ff;

   logic                                 ki_neg;
   logic [KI_ERR_WIDTH-1:0]              ki_mag;
   logic [13:0]                          ki_div8;
   logic [28:0]                          ki_prod;
   logic [12:0]                          ki_quot;
   logic signed [13:0]                   inc;
   logic signed [INTEGRAL_WIDTH:0]       int_sum;
   logic signed [D_WIDTH-1:0]            d_term;
   logic signed [SUM_WIDTH-1:0]          total;

   always_comb begin
      // ki*err/40 toward zero: divide the magnitude by 8, then by 5
      ki_neg  = word.ki_err[KI_ERR_WIDTH-1];
      ki_mag  = ki_neg ? KI_ERR_WIDTH'(-word.ki_err) : KI_ERR_WIDTH'(word.ki_err);
      ki_div8 = ki_mag[16:3];
      ki_prod = {15'd0, ki_div8} * 29'(RECIP5);
      ki_quot = ki_prod[RECIP5_SHIFT +: 13];
      inc     = ki_neg ? -$signed({1'b0, ki_quot}) : $signed({1'b0, ki_quot});

      int_sum = $signed({integral_ff[INTEGRAL_WIDTH-1], integral_ff})
              + (INTEGRAL_WIDTH+1)'(inc);
      if (int_sum > (INTEGRAL_WIDTH+1)'(INTEGRAL_MAX)) begin
         integral_in = INTEGRAL_MAX;
      end else if (int_sum < (INTEGRAL_WIDTH+1)'(INTEGRAL_MIN)) begin
         integral_in = INTEGRAL_MIN;
      end else begin
         integral_in = int_sum[INTEGRAL_WIDTH-1:0];
      end

      // times 40 as 32 + 8
      d_term = (D_WIDTH'(word.kd_diff) <<< 5) + (D_WIDTH'(word.kd_diff) <<< 3);

      total = SUM_WIDTH'($signed({1'b0, drive_ff}))
            + SUM_WIDTH'(word.p)
            + SUM_WIDTH'(integral_in)
            + SUM_WIDTH'(d_term);

      if (total < SUM_WIDTH'(1)) begin
         drive_in = DRIVE_WIDTH'(1);
      end else if (total > SUM_WIDTH'(DUTY_MAX)) begin
         drive_in = DRIVE_WIDTH'(DUTY_MAX);
      end else begin
         drive_in = total[DRIVE_WIDTH-1:0];
      end

      if (32'(drive_in) > 32'(PWM_CAP)) begin
         duty_in = DUTY_WIDTH'(PWM_CAP);
      end else begin
         duty_in = DUTY_WIDTH'(drive_in);
      end
   end

   always_comb begin
      priority if (ctl.move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff  <= '0;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (ctl.move) begin
            integral_ff <= integral_in;
            drive_ff    <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.move) begin
         duty_ff  <= duty_in;
         speed_ff <= word.speed;
         error_ff <= word.err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_cycle  = duty_ff;
   assign rsp_speed_rpm   = speed_ff;
   assign rsp_speed_error = error_ff;

endmodule

[sv/motor_speed_pid_step_unit.sv]
// Incremental PID speed step unit: handshake control, gain registers, two stages.
// Depends on mspid_pkg, mspid_err_stage and mspid_acc_stage.
//
// Usage:
//   req_ channel: req_command 0 counts one encoder pulse, 1 is a sample tick
//   carrying req_setpoint_raw. A word is taken when req_valid is high and
//   req_stall is low. Pulse words give no result; each tick gives one word on
//   the rsp_ channel (duty, speed, error), taken when rsp_valid is high and
//   rsp_stall is low.
//   csr_ channel: writes kp, ki, kd by index; csr_ready is always high and an
//   unknown index is dropped. Write gains only while the unit is idle.
//   Path: a tick taken is first held in the first-stage word register and then
//   moves to the result register. Throughput: one word per cycle while req_stall
//   is low, pulses and ticks alike, set by the accumulate step feeding integral and drive.
//   Reset clears the pulse count, integral, drive level, previous error and
//   restores the gains to 3, 1, 1. When the receiver stalls, the result holds,
//   the first stage holds one tick, and only then is req_stall raised.
`timescale 1ns / 1ps

module motor_speed_pid_step_unit #(
   parameter int DUTY_MAX = mspid_pkg::DUTY_MAX_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic                                        req_command,
   input  logic [mspid_pkg::RAW_WIDTH-1:0]             req_setpoint_raw,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [mspid_pkg::DUTY_WIDTH-1:0]            rsp_duty_cycle,
   output logic [mspid_pkg::SPEED_WIDTH-1:0]           rsp_speed_rpm,
   output logic signed [mspid_pkg::ERR_WIDTH-1:0]      rsp_speed_error,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [mspid_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [mspid_pkg::GAIN_WIDTH-1:0]            csr_wdata
);
   import mspid_pkg::*;

   logic [GAIN_WIDTH-1:0]   kp_ff, kp_in;
   logic [GAIN_WIDTH-1:0]   ki_ff, ki_in;
   logic [GAIN_WIDTH-1:0]   kd_ff, kd_in;

   pipe_ctl_type            ctl;
   logic                    req_accept;
   logic                    word_valid;
   err_word_type            word;

   // the first stage drains whenever the result register is free or being taken
   assign ctl.move       = word_valid && (!rsp_valid || !rsp_stall);
   assign req_stall      = word_valid && rsp_valid && rsp_stall;
   assign req_accept     = req_valid && !req_stall;
   assign ctl.load_tick  = req_accept && (req_command == CMD_TICK);
   assign ctl.load_pulse = req_accept && (req_command == CMD_PULSE);

   assign csr_ready = 1'b1;

   always_comb begin
      kp_in = kp_ff;
      ki_in = ki_ff;
      kd_in = kd_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_KP:  kp_in = csr_wdata;
            REG_KI:  ki_in = csr_wdata;
            REG_KD:  kd_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= KP_RESET;
         ki_ff <= KI_RESET;
         kd_ff <= KD_RESET;
      end else begin
         kp_ff <= kp_in;
         ki_ff <= ki_in;
         kd_ff <= kd_in;
      end
   end

   mspid_err_stage u_err_stage (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .setpoint_raw (req_setpoint_raw),
      .kp           (kp_ff),
      .ki           (ki_ff),
      .kd           (kd_ff),
      .word_valid   (word_valid),
      .word         (word)
   );

   mspid_acc_stage #(
      .DUTY_MAX (DUTY_MAX)
   ) u_acc_stage (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .word            (word),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_duty_cycle  (rsp_duty_cycle),
      .rsp_speed_rpm   (rsp_speed_rpm),
      .rsp_speed_error (rsp_speed_error)
   );

endmodule

[sv/mspid_checker.sv]
// Port-level checker of the PID speed step unit, bound to the top level.
// Depends on mspid_pkg and motor_speed_pid_step_unit_macros.svh.
`timescale 1ns / 1ps
`include "motor_speed_pid_step_unit_macros.svh"

module mspid_checker (
   input logic                                        clock,
   input logic                                        reset,
   input logic                                        req_valid,
   input logic                                        req_stall,
   input logic                                        req_command,
   input logic [mspid_pkg::RAW_WIDTH-1:0]             req_setpoint_raw,
   input logic                                        rsp_valid,
   input logic                                        rsp_stall,
   input logic [mspid_pkg::DUTY_WIDTH-1:0]            rsp_duty_cycle,
   input logic [mspid_pkg::SPEED_WIDTH-1:0]           rsp_speed_rpm,
   input logic signed [mspid_pkg::ERR_WIDTH-1:0]      rsp_speed_error,
   input logic                                        csr_valid,
   input logic                                        csr_ready,
   input logic [mspid_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input logic [mspid_pkg::GAIN_WIDTH-1:0]            csr_wdata
);
   import mspid_pkg::*;

   `MSPID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_duty_cycle), "stalled result word changed or dropped")

   `MSPID_ASSERT_NOW(a_duty_nonzero, clock, reset, rsp_valid,
      rsp_duty_cycle != '0, "duty cycle below the lower clamp")

   `MSPID_ASSERT_NOW(a_error_range, clock, reset, rsp_valid,
      (rsp_speed_error >= -10'sd255) && (rsp_speed_error <= 10'sd359),
      "speed error outside the setpoint and speed span")

   `MSPID_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset,
      !rsp_valid && !req_stall, "unit not idle right after reset")

endmodule

bind motor_speed_pid_step_unit mspid_checker u_mspid_checker (.*);
